[hdl/jlt_pkg.sv]
package jlt_pkg;

	localparam int MAX_JOBS_DEF = 16;

	// request kinds carried on s_tuser
	localparam logic [2:0] MODE_OFFER  = 3'd0;
	localparam logic [2:0] MODE_CLAIM  = 3'd1;
	localparam logic [2:0] MODE_SUBMIT = 3'd2;
	localparam logic [2:0] MODE_CANCEL = 3'd3;
	localparam logic [2:0] MODE_QUERY  = 3'd4;
	localparam logic [2:0] MODE_POLL   = 3'd5;

	// job lifecycle codes
	localparam logic [2:0] JS_IDLE    = 3'd0;
	localparam logic [2:0] JS_OFFERED = 3'd1;
	localparam logic [2:0] JS_CLAIMED = 3'd2;
	localparam logic [2:0] JS_RUNNING = 3'd3;
	localparam logic [2:0] JS_DONE    = 3'd4;
	localparam logic [2:0] JS_FAILED  = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_WRONG     = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	localparam logic [15:0] LIMIT_RST   = 16'd4096;
	localparam logic [31:0] NEXT_ID_RST = 32'd1;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 104;
	localparam int COUNT_W    = 5;

	typedef struct packed {
		logic [15:0] len;
		logic [31:0] peer;
		logic [2:0]  state;
		logic [31:0] id;
	} ent_t;

endpackage

[hdl/jlt_ram.sv]
module jlt_ram #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  jlt_pkg::ent_t   wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output jlt_pkg::ent_t   rd_data
);
	import jlt_pkg::*;

	ent_t mem [DEPTH];
	ent_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/job_lifecycle_table.sv]
// Sequence: offer, poll and unused kinds go from capture straight to the response state;
// claim, submit, cancel and query scan the live entries for the id, respond on a miss,
// act on a hit, and a cancel that moves the last entry adds a copy before responding.
// Throughput: one request at a time; the next is taken once the result loads, which waits
// while the output holds an untaken result; the id scan reads one entry per cycle.
// Reset: arst_n clears control, counts, next id (to 1) and the limit (to 4096), not the RAM.
module job_lifecycle_table #(
	parameter int MAX_JOBS = jlt_pkg::MAX_JOBS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [15:0]                   cfg_wr_data,   // artifact_limit
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// job_id[31:0], peer_id[63:32], compile_ok[64], artifact_present[65],
	// art_len[81:66], zero pad[87:82]
	input  logic [jlt_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [2:0]                    s_tuser,       // mode[2:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status_code[1:0], new_id[33:2], job_state[36:34], job_peer[68:37],
	// job_art_len[84:69], changed[85], live_count[90:86],
	// pending_count[95:91], running_count[100:96], zero pad[103:101]
	output logic [jlt_pkg::OUT_DATA_W-1:0] m_tdata
);
	import jlt_pkg::*;

	// slot index width and a count width that can hold MAX_JOBS itself
	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_ACT  = 3'd2;
	localparam logic [2:0] S_COPY = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]  state_q;

	// captured request
	logic [2:0]  mode_q;
	logic [31:0] id_q;
	logic [31:0] peer_q;
	logic        ok_q;
	logic        pres_q;
	logic [15:0] len_q;

	// table bookkeeping
	logic [15:0]   limit_q;
	logic [CW-1:0] live_q;
	logic [CW-1:0] pend_q;
	logic [31:0]   next_id_q;
	logic          change_q;

	// scan pipeline: read issued in one cycle, compared in the next
	logic [CW-1:0] scan_q;
	logic          chk_s1;
	logic [IW-1:0] chk_idx_s1;
	logic [IW-1:0] hit_idx_q;
	ent_t          hit_q;

	// response fields
	logic [1:0]  status_q;
	logic [31:0] new_id_q;
	logic        changed_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// RAM port
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	ent_t          rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	ent_t          wr_data;

	logic          accept;
	logic          full;
	logic          scan_more;
	logic          hit;
	logic [CW-1:0] last_c;
	logic          move_last;
	logic          submit_good;
	logic          resp_go;

	logic [31:0] in_id;
	logic [31:0] in_peer;
	logic        in_ok;
	logic        in_pres;
	logic [15:0] in_len;

	assign in_id   = s_tdata[31:0];
	assign in_peer = s_tdata[63:32];
	assign in_ok   = s_tdata[64];
	assign in_pres = s_tdata[65];
	assign in_len  = s_tdata[81:66];

	// one request in flight; the output register holds a finished result on its own
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign full      = (live_q >= CW'(MAX_JOBS));
	assign scan_more = (scan_q < live_q);
	assign hit       = chk_s1 && (rd_data.id == id_q);
	assign last_c    = live_q - CW'(1);
	// the entry to drop is not the last one: refill its slot from the last
	assign move_last = (CW'(hit_idx_q) < last_c);
	assign submit_good = ok_q && pres_q && (len_q != 16'd0) && (len_q <= limit_q);
	assign resp_go   = !m_tvalid_q || m_tready;

	// RAM access steering
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = hit_q;
		case (state_q)
			S_IDLE: begin
				// append the offered job at the end of the live region
				wr_addr = live_q[IW-1:0];
				wr_data = '{len: 16'd0, peer: 32'd0, state: JS_OFFERED, id: next_id_q};
				wr_en   = accept && (s_tuser == MODE_OFFER) && !full;
			end
			S_SCAN: begin
				rd_en = scan_more;
			end
			S_ACT: begin
				case (mode_q)
					MODE_CLAIM: begin
						wr_data.peer  = peer_q;
						wr_data.state = JS_CLAIMED;
						wr_en = (hit_q.state == JS_OFFERED);
					end
					MODE_SUBMIT: begin
						if (submit_good) begin
							wr_data.len   = len_q;
							wr_data.state = JS_DONE;
						end else begin
							wr_data.state = JS_FAILED;
						end
						wr_en = (hit_q.state == JS_CLAIMED) || (hit_q.state == JS_RUNNING);
					end
					MODE_CANCEL: begin
						// fetch the last entry for the move into the freed slot
						rd_addr = last_c[IW-1:0];
						rd_en   = (hit_q.state != JS_DONE) && (hit_q.state != JS_FAILED)
							&& move_last;
					end
					default: begin
					end
				endcase
			end
			S_COPY: begin
				wr_data = rd_data;
				wr_en   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	jlt_ram #(
		.DEPTH (MAX_JOBS),
		.AW    (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// request capture; payload only, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			id_q   <= in_id;
			peer_q <= in_peer;
			ok_q   <= in_ok;
			pres_q <= in_pres;
			len_q  <= in_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// sequencer: capture, scan, act, optional move, respond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			live_q     <= '0;
			pend_q     <= '0;
			next_id_q  <= NEXT_ID_RST;
			change_q   <= 1'b0;
			scan_q     <= '0;
			chk_s1     <= 1'b0;
			chk_idx_s1 <= '0;
			hit_idx_q  <= '0;
			hit_q      <= '0;
			status_q   <= STAT_OK;
			new_id_q   <= '0;
			changed_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q  <= STAT_OK;
						new_id_q  <= '0;
						changed_q <= 1'b0;
						scan_q    <= '0;
						chk_s1    <= 1'b0;
						case (s_tuser)
							MODE_OFFER: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									new_id_q  <= next_id_q;
									next_id_q <= next_id_q + 32'd1;
									live_q    <= live_q + CW'(1);
									pend_q    <= pend_q + CW'(1);
									change_q  <= 1'b1;
								end
								state_q <= S_RESP;
							end
							MODE_POLL: begin
								// read and clear the change flag
								changed_q <= change_q;
								change_q  <= 1'b0;
								state_q   <= S_RESP;
							end
							MODE_CLAIM, MODE_SUBMIT, MODE_CANCEL, MODE_QUERY: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					// issue the next slot while comparing the one read last cycle
					chk_s1     <= scan_more;
					chk_idx_s1 <= scan_q[IW-1:0];
					if (scan_more) begin
						scan_q <= scan_q + CW'(1);
					end
					if (hit) begin
						hit_q     <= rd_data;
						hit_idx_q <= chk_idx_s1;
						state_q   <= S_ACT;
					end else if (!scan_more) begin
						status_q <= STAT_NOT_FOUND;
						state_q  <= S_RESP;
					end
				end
				S_ACT: begin
					state_q <= S_RESP;
					case (mode_q)
						MODE_CLAIM: begin
							if (hit_q.state != JS_OFFERED) begin
								status_q <= STAT_WRONG;
							end else begin
								change_q <= 1'b1;
							end
						end
						MODE_SUBMIT: begin
							if ((hit_q.state != JS_CLAIMED) && (hit_q.state != JS_RUNNING)) begin
								status_q <= STAT_WRONG;
							end else begin
								if (hit_q.state == JS_CLAIMED) begin
									pend_q <= pend_q - CW'(1);
								end
								change_q <= 1'b1;
							end
						end
						MODE_CANCEL: begin
							// a finished job stays put and answers ok
							if ((hit_q.state != JS_DONE) && (hit_q.state != JS_FAILED)) begin
								if ((hit_q.state == JS_OFFERED) || (hit_q.state == JS_CLAIMED)) begin
									pend_q <= pend_q - CW'(1);
								end
								live_q   <= last_c;
								change_q <= 1'b1;
								if (move_last) begin
									state_q <= S_COPY;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_COPY: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register: load the result, drop it once taken
	logic        q_sel;
	logic [2:0]  q_state;
	logic [31:0] q_peer;
	logic [15:0] q_len;

	assign q_sel   = (mode_q == MODE_QUERY) && (status_q == STAT_OK);
	assign q_state = q_sel ? hit_q.state : 3'd0;
	assign q_peer  = q_sel ? hit_q.peer : 32'd0;
	assign q_len   = q_sel ? hit_q.len : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if ((state_q == S_RESP) && resp_go) begin
				m_tvalid_q <= 1'b1;
			end
		end
	end

	// no request ever moves a job to running, so the running count stays zero
	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && resp_go) begin
			m_tdata_q <= {3'd0, COUNT_W'(0), COUNT_W'(pend_q), COUNT_W'(live_q), changed_q,
				q_len, q_peer, q_state, new_id_q, status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	a_live_max: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(MAX_JOBS))
		else $error("live count beyond table size");

	a_pend_le_live: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= live_q)
		else $error("pending count above live count");

	a_offer_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == MODE_OFFER) && !full) |=> (live_q == $past(live_q) + CW'(1)))
		else $error("offer did not append an entry");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_q <= live_q))
		else $error("scan ran past the live region");
`endif

endmodule

[tb/job_lifecycle_table_test.sv]
module job_lifecycle_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import jlt_pkg::*;

	// Kinds 6 and 7 have no meaning; the block answers them with the counts only.
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	// Masks over lifecycle codes, used to steer job ids toward slots in a given state.
	localparam logic [7:0] M_OFFERED = 8'h01 << JS_OFFERED;
	localparam logic [7:0] M_CLAIMED = 8'h01 << JS_CLAIMED;
	localparam logic [7:0] M_OPEN    = M_OFFERED | M_CLAIMED | (8'h01 << JS_RUNNING);
	localparam logic [7:0] M_CLOSED  = (8'h01 << JS_DONE) | (8'h01 << JS_FAILED);
	localparam logic [7:0] M_LIVE    = M_OPEN | M_CLOSED;
	localparam logic [7:0] M_HELD    = M_OFFERED | M_CLOSED;

	localparam int SLOTS        = MAX_JOBS_DEF;
	localparam int PHASE_ITEMS  = 420;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int SETTLE       = 40;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] id;
		logic [31:0] peer;
		logic        ok;
		logic        present;
		logic [15:0] len;
	} job_req_t;

	// Laid out MSB first so that m_tdata[100:0] casts straight onto it.
	typedef struct packed {
		logic [4:0]  run;
		logic [4:0]  pend;
		logic [4:0]  live;
		logic        changed;
		logic [15:0] alen;
		logic [31:0] peer;
		logic [2:0]  state;
		logic [31:0] new_id;
		logic [1:0]  status;
	} job_reply_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [15:0]            cfg_wr_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [2:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;

	job_lifecycle_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow of the job table, advanced once per accepted request.
	ent_t        slots [SLOTS];
	int          live_n;
	logic [31:0] next_id;
	bit          dirty;
	logic [15:0] limit_q;

	job_req_t    pending[$];       // requests waiting for the driver
	job_reply_t  replies_due[$];   // predicted replies, oldest first

	int sent_cnt = 0;    // requests put on the bus
	int taken_cnt = 0;   // requests accepted by the block
	int reply_cnt = 0;
	int err_cnt = 0;
	int stall_cycles = 0;
	int mode_cnt [8];
	int stat_cnt [4];

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	logic [15:0] cur_lim;

	// Apply one request to the shadow table and return the reply it must produce.
	function automatic job_reply_t job_table_step(logic [2:0] mode, logic [31:0] id,
			logic [31:0] peer, logic ok, logic present, logic [15:0] len);
		job_reply_t r;
		int hit;
		int last;
		int i;
		r = '0;
		hit = -1;
		// first live, non-idle slot with this id wins
		for (i = 0; i < live_n; i++)
			if (hit < 0 && slots[i].state != JS_IDLE && slots[i].id == id)
				hit = i;
		case (mode)
			MODE_OFFER: begin
				if (live_n >= SLOTS) begin
					r.status = STAT_FULL;
				end else begin
					slots[live_n] = '{len: '0, peer: '0, state: JS_OFFERED, id: next_id};
					r.new_id = next_id;
					next_id = next_id + 32'd1;
					live_n++;
					dirty = 1'b1;
				end
			end
			MODE_CLAIM: begin
				if (hit < 0) begin
					r.status = STAT_NOT_FOUND;
				end else if (slots[hit].state != JS_OFFERED) begin
					r.status = STAT_WRONG;
				end else begin
					slots[hit].peer = peer;
					slots[hit].state = JS_CLAIMED;
					dirty = 1'b1;
				end
			end
			MODE_SUBMIT: begin
				if (hit < 0) begin
					r.status = STAT_NOT_FOUND;
				end else if (slots[hit].state != JS_CLAIMED && slots[hit].state != JS_RUNNING) begin
					r.status = STAT_WRONG;
				end else begin
					if (ok && present && len != 16'd0 && len <= limit_q) begin
						slots[hit].len = len;
						slots[hit].state = JS_DONE;
					end else begin
						// failed jobs keep whatever length they had
						slots[hit].state = JS_FAILED;
					end
					dirty = 1'b1;
				end
			end
			MODE_CANCEL: begin
				if (hit < 0) begin
					r.status = STAT_NOT_FOUND;
				end else if (slots[hit].state != JS_DONE && slots[hit].state != JS_FAILED) begin
					// compact: last entry moves into the freed slot
					last = live_n - 1;
					if (hit < last)
						slots[hit] = slots[last];
					slots[last] = '0;
					live_n = last;
					dirty = 1'b1;
				end
				// cancel of a finished job answers ok and leaves the table alone
			end
			MODE_QUERY: begin
				if (hit < 0) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					r.state = slots[hit].state;
					r.peer = slots[hit].peer;
					r.alen = slots[hit].len;
				end
			end
			MODE_POLL: begin
				r.changed = dirty;
				dirty = 1'b0;
			end
			default: ;
		endcase
		for (i = 0; i < live_n; i++) begin
			if (slots[i].state == JS_OFFERED || slots[i].state == JS_CLAIMED)
				r.pend++;
			else if (slots[i].state == JS_RUNNING)
				r.run++;
		end
		r.live = 5'(live_n);
		return r;
	endfunction

	// An id that is not (or is unlikely to be) in the table.
	function automatic logic [31:0] stray_id();
		case ($urandom_range(0, 3))
			0, 1: return $urandom;
			2: return next_id;
			default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	// Id of a random live slot whose state is in the mask; stray id if there is none.
	function automatic logic [31:0] pick_id(logic [7:0] mask);
		int cand[$];
		int i;
		for (i = 0; i < live_n; i++)
			if (mask[slots[i].state])
				cand.push_back(i);
		if (cand.size() == 0)
			return stray_id();
		return slots[cand[$urandom_range(0, cand.size() - 1)]].id;
	endfunction

	// Build one random request. Ids are steered from the shadow table so that most
	// requests hit live jobs. Finished jobs never leave the table, so successful
	// submits are rationed by cap to keep slots free for new offers.
	function automatic job_req_t make_request(int cap);
		job_req_t r;
		int closed;
		int roll;
		int i;
		closed = 0;
		for (i = 0; i < live_n; i++)
			if (slots[i].state == JS_DONE || slots[i].state == JS_FAILED)
				closed++;
		r.peer = $urandom;
		r.ok = ($urandom_range(0, 99) < 85);
		r.present = ($urandom_range(0, 99) < 85);
		case ($urandom_range(0, 5))
			0: r.len = '0;
			1: r.len = cur_lim;
			2: r.len = cur_lim + 16'd1;
			3: r.len = cur_lim - 16'd1;
			4: r.len = 16'($urandom_range(1, 64));
			default: r.len = 16'($urandom);
		endcase
		r.id = stray_id();
		roll = $urandom_range(0, 99);
		if (roll < 22) begin
			r.mode = MODE_OFFER;
		end else if (roll < 42) begin
			r.mode = MODE_CLAIM;
			roll = $urandom_range(0, 99);
			if (roll < 75)
				r.id = pick_id(M_OFFERED);
			else if (roll < 90)
				r.id = pick_id(M_LIVE);
		end else if (roll < 58) begin
			r.mode = MODE_SUBMIT;
			roll = $urandom_range(0, 99);
			if (closed < cap && roll < 75)
				r.id = pick_id(M_CLAIMED);
			else if (closed < cap && roll < 90)
				r.id = pick_id(M_LIVE);
			else if (closed >= cap && roll < 85)
				r.id = pick_id(M_HELD);
		end else if (roll < 72) begin
			r.mode = MODE_CANCEL;
			roll = $urandom_range(0, 99);
			if (roll < 65)
				r.id = pick_id(M_OPEN);
			else if (roll < 85)
				r.id = pick_id(M_CLOSED);
		end else if (roll < 86) begin
			r.mode = MODE_QUERY;
			if ($urandom_range(0, 99) < 80)
				r.id = pick_id(M_LIVE);
		end else if (roll < 96) begin
			r.mode = MODE_POLL;
		end else begin
			r.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
		end
		return r;
	endfunction

	task automatic queue_req(logic [2:0] mode, logic [31:0] id, logic [31:0] peer,
			logic ok, logic present, logic [15:0] len);
		pending.push_back('{mode: mode, id: id, peer: peer, ok: ok, present: present, len: len});
	endtask

	// Step just past a rising edge, where the shadow table and counters are settled.
	task automatic tick();
		@(posedge clk);
		#1;
	endtask

	// Hold off until the block has answered everything sent so far.
	task automatic wait_idle();
		while (pending.size() != 0 || taken_cnt != sent_cnt || replies_due.size() != 0)
			tick();
	endtask

	// Write the limit register at a falling edge; the block must be idle.
	task automatic write_limit(logic [15:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		cur_lim = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: reply %0d %s mismatch: expected %0h, actual %0h",
				$time, reply_cnt, what, want, got);
			err_cnt++;
		end
	endtask

	// Driver: present a new request at the falling edge once the previous one is taken.
	// Hold s_tvalid across back-to-back requests so it only gets one update per edge.
	always @(negedge clk) begin : drive
		job_req_t req;
		if (arst_n) begin
			if (s_tvalid && taken_cnt != sent_cnt) begin
				// hold the current request until the block takes it
			end else if (pending.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
				req = pending.pop_front();
				s_tuser <= req.mode;
				s_tdata <= {6'b0, req.len, req.present, req.ok, req.peer, req.id};
				s_tvalid <= 1'b1;
				sent_cnt <= sent_cnt + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	// Monitor: predict on every accepted request, check every accepted reply,
	// and watch for the handshakes drying up.
	always @(posedge clk) begin : watch
		job_reply_t want;
		job_reply_t got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_wr_en)
				limit_q = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				want = job_table_step(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[64],
					s_tdata[65], s_tdata[81:66]);
				replies_due.push_back(want);
				mode_cnt[s_tuser]++;
				taken_cnt++;
				moved = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got = job_reply_t'(m_tdata[100:0]);
				reply_cnt++;
				stat_cnt[got.status]++;
				moved = 1'b1;
				if (replies_due.size() == 0) begin
					$display("%0t: reply %0d arrived with nothing outstanding, actual %0h",
						$time, reply_cnt, got);
					err_cnt++;
				end else begin
					want = replies_due.pop_front();
					check_field("status_code", want.status, got.status);
					check_field("new_id", want.new_id, got.new_id);
					check_field("job_state", want.state, got.state);
					check_field("job_peer", want.peer, got.peer);
					check_field("job_art_len", want.alen, got.alen);
					check_field("changed", want.changed, got.changed);
					check_field("live_count", want.live, got.live);
					check_field("pending_count", want.pend, got.pend);
					check_field("running_count", want.run, got.run);
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d replies outstanding",
					$time, STALL_LIMIT, replies_due.size());
				$display("** job_lifecycle_table: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [15:0] phase_lim [4];
		int          snd_pct [4];
		int          rcv_pct [4];
		int          caps [4];
		job_req_t    r;
		int          ph;
		int          n;
		int          i;

		// clear the shadow table to its reset contents
		for (i = 0; i < SLOTS; i++)
			slots[i] = '0;
		live_n = 0;
		next_id = NEXT_ID_RST;
		dirty = 1'b0;
		limit_q = LIMIT_RST;
		cur_lim = LIMIT_RST;
		for (i = 0; i < 8; i++)
			mode_cnt[i] = 0;
		for (i = 0; i < 4; i++)
			stat_cnt[i] = 0;

		phase_lim = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom_range(2, 65534))};
		snd_pct = '{28, 60, 0, 0};
		rcv_pct = '{60, 28, 0, 0};
		caps = '{5, 8, 11, 12};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed walk through the lifecycle at the reset limit; ids start at 1.
		queue_req(MODE_POLL, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);           // nothing changed yet
		queue_req(MODE_QUERY, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);          // empty table: miss
		queue_req(MODE_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
		queue_req(MODE_SPARE_B, 32'h1, 32'h0, 1'b0, 1'b0, 16'h0);
		queue_req(MODE_OFFER, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);          // id 1
		queue_req(MODE_OFFER, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);          // id 2
		queue_req(MODE_POLL, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);           // flag set
		queue_req(MODE_POLL, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);           // flag cleared
		queue_req(MODE_CLAIM, 32'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0);
		queue_req(MODE_CLAIM, 32'd1, 32'h0, 1'b0, 1'b0, 16'h0);          // already claimed
		queue_req(MODE_SUBMIT, 32'd2, 32'h0, 1'b1, 1'b1, 16'd10);        // still offered
		queue_req(MODE_SUBMIT, 32'd1, 32'h0, 1'b1, 1'b1, LIMIT_RST);     // length at limit: done
		queue_req(MODE_QUERY, 32'd1, 32'h0, 1'b0, 1'b0, 16'h0);
		queue_req(MODE_CANCEL, 32'd1, 32'h0, 1'b0, 1'b0, 16'h0);         // finished: no change
		queue_req(MODE_POLL, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);
		queue_req(MODE_CLAIM, 32'd2, 32'h0, 1'b0, 1'b0, 16'h0);
		queue_req(MODE_SUBMIT, 32'd2, 32'h0, 1'b1, 1'b1, LIMIT_RST + 16'd1); // over limit: failed
		queue_req(MODE_OFFER, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);          // id 3
		queue_req(MODE_CLAIM, 32'd3, 32'hA5A5_A5A5, 1'b0, 1'b0, 16'h0);
		queue_req(MODE_SUBMIT, 32'd3, 32'h0, 1'b1, 1'b0, 16'd16);        // no artifact: failed
		queue_req(MODE_OFFER, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);          // id 4
		queue_req(MODE_OFFER, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);          // id 5
		queue_req(MODE_CANCEL, 32'd4, 32'h0, 1'b0, 1'b0, 16'h0);         // id 5 moves down
		queue_req(MODE_QUERY, 32'd5, 32'h0, 1'b0, 1'b0, 16'h0);
		queue_req(MODE_CANCEL, 32'd5, 32'h0, 1'b0, 1'b0, 16'h0);         // last slot
		queue_req(MODE_SUBMIT, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 16'd1); // unknown id
		wait_idle();

		// Random phases: each starts idle with a new limit and a new idling pattern.
		for (ph = 0; ph < 4; ph++) begin
			write_limit(phase_lim[ph]);
			snd_idle_pct = snd_pct[ph];
			rcv_idle_pct = rcv_pct[ph];
			n = 0;
			while (n < PHASE_ITEMS) begin
				while (pending.size() >= 2)
					tick();
				r = make_request(caps[ph]);
				pending.push_back(r);
				if (r.mode != MODE_SPARE_A && r.mode != MODE_SPARE_B) begin
					n++;
					// stall the reply side for a long stretch while requests keep coming
					if (ph == 2 && n == 100)
						hold_req = ~hold_req;
				end
			end
			wait_idle();
		end

		// let any stray late reply show up before the verdict
		repeat (SETTLE) tick();
		if (replies_due.size() != 0) begin
			$display("%0t: %0d predicted replies never arrived", $time, replies_due.size());
			err_cnt += replies_due.size();
		end

		$display(
			"%0d requests: offer %0d claim %0d submit %0d cancel %0d query %0d poll %0d spare %0d",
			taken_cnt, mode_cnt[MODE_OFFER], mode_cnt[MODE_CLAIM], mode_cnt[MODE_SUBMIT],
			mode_cnt[MODE_CANCEL], mode_cnt[MODE_QUERY], mode_cnt[MODE_POLL],
			mode_cnt[MODE_SPARE_A] + mode_cnt[MODE_SPARE_B]);
		$display("replies: ok %0d, not found %0d, wrong state %0d, full %0d; limits 4096 ffff 0 1 %0h",
			stat_cnt[STAT_OK], stat_cnt[STAT_NOT_FOUND], stat_cnt[STAT_WRONG],
			stat_cnt[STAT_FULL], phase_lim[3]);
		if (err_cnt == 0) begin
			$display("** job_lifecycle_table: PASSED **");
		end else begin
			$display("** job_lifecycle_table: FAILED **");
		end
		$finish;
	end

endmodule
